### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held low.
`define MRTU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication built on the macro above.
`define MRTU_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `MRTU_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

### sv/mrtu_pkg.sv
package mrtu_pkg;

    // Request codes
    localparam logic [2:0] FN_RX_BYTE  = 3'd0;
    localparam logic [2:0] FN_EXPIRY   = 3'd1;
    localparam logic [2:0] FN_TX_READY = 3'd2;
    localparam logic [2:0] FN_BUF_WR   = 3'd3;
    localparam logic [2:0] FN_BUF_RD   = 3'd4;
    localparam logic [2:0] FN_SEND     = 3'd5;
    localparam logic [2:0] FN_START    = 3'd6;

    // Event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_INIT_DONE = 3'd1;
    localparam logic [2:0] EV_FRAME_RX  = 3'd2;
    localparam logic [2:0] EV_TX_BYTE   = 3'd3;
    localparam logic [2:0] EV_SENT      = 3'd4;
    localparam logic [2:0] EV_RD_DATA   = 3'd5;
    localparam logic [2:0] EV_SEND_OK   = 3'd6;
    localparam logic [2:0] EV_SEND_NAK  = 3'd7;

    // Modbus CRC-16, reflected
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data;
        logic       parity_error;
        logic       framing_error;
        logic [7:0] index;
        logic [7:0] slave_id;
        logic [7:0] tx_pdu_length;
    } t_in;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] byte_out;
        logic       tx_last;
        logic [7:0] address;
        logic [7:0] rx_pdu_length;
        logic       frame_ok;
        logic       receiver_on;
        logic       driver_on;
    } t_out;

    // One byte through the CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/mrtu_ram.sv
module mrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mrtu_crc.sv
module mrtu_crc
    import mrtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_clear,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;

    // Byte-wide CRC accumulator, one byte per cycle while i_en is high
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_crc <= CRC_INIT;
        end else if (i_en) begin
            r_crc <= crc_byte(r_crc, i_byte);
        end
    end

    assign o_crc = r_crc;

endmodule

### sv/modbus_rtu_frame_engine.sv
// Modbus RTU frame engine. Each request (received byte, t3.5 expiry, transmitter
// ready, buffer write or read, send, start) yields exactly one result transfer.
// The frame buffer is one BUF_BYTES x 8 synchronous RAM shared by receive, host
// access and transmit; its contents are undefined until written. All requests
// except an accepted send pass through accept, buffer read and result hand-off.
// An accepted send instead has the CRC-16 pass walk the PDU through the RAM's
// single read port at one byte per cycle, then writes the two CRC bytes back. A new
// request is taken while the previous result still waits on the output register.
module modbus_rtu_frame_engine
    import mrtu_pkg::*;
#(
    parameter int BUF_BYTES = 256,
    parameter int MIN_FRAME = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = $clog2(BUF_BYTES + 1);
    localparam logic [8:0]    LIM9     = 9'(BUF_BYTES);
    localparam logic [CW-1:0] LIM_CNT  = CW'(BUF_BYTES);
    localparam logic [CW-1:0] MIN_CNT  = CW'(MIN_FRAME);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_SID, S_CRC, S_WLO, S_WHI, S_PUT
    } t_state;

    typedef enum logic [1:0] {
        M_INIT, M_IDLE, M_RCV, M_ERR
    } t_mode;

    t_state         r_state, n_state;
    t_mode          r_mode, n_mode;
    logic           r_tx_busy, n_tx_busy;
    logic [CW-1:0]  r_rx_count, n_rx_count;
    logic [AW-1:0]  r_tx_pos, n_tx_pos;
    logic [CW-1:0]  r_tx_rem, n_tx_rem;
    logic           r_rx_en, n_rx_en;
    logic           r_drv_en, n_drv_en;
    logic           r_fill_byte, n_fill_byte;
    logic           r_fill_addr, n_fill_addr;
    logic           r_pend, n_pend;
    logic           r_out_valid, n_out_valid;
    t_out           r_res, n_res;
    t_out           r_out, n_out;
    logic [7:0]     r_sid, n_sid;
    logic [7:0]     r_plen, n_plen;
    logic [AW-1:0]  r_ptr, n_ptr;
    logic [7:0]     r_left, n_left;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [7:0]     mem_rdata;

    logic           crc_clear;
    logic           crc_en;
    logic [7:0]     crc_in;
    logic [15:0]    crc_val;

    mrtu_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mrtu_crc u_crc (
        .i_clk   (i_clk),
        .i_clear (crc_clear),
        .i_en    (crc_en),
        .i_byte  (crc_in),
        .o_crc   (crc_val)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Sequencer next-state and buffer port control
    always_comb begin
        t_mode      v_mode;
        logic [8:0] v_rlen;
        v_mode      = r_mode;
        v_rlen      = 9'(r_rx_count) - 9'd3;
        n_state     = r_state;
        n_mode      = r_mode;
        n_tx_busy   = r_tx_busy;
        n_rx_count  = r_rx_count;
        n_tx_pos    = r_tx_pos;
        n_tx_rem    = r_tx_rem;
        n_rx_en     = r_rx_en;
        n_drv_en    = r_drv_en;
        n_fill_byte = r_fill_byte;
        n_fill_addr = r_fill_addr;
        n_pend      = r_pend;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_sid       = r_sid;
        n_plen      = r_plen;
        n_ptr       = r_ptr;
        n_left      = r_left;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        crc_clear   = 1'b0;
        crc_en      = 1'b0;
        crc_in      = mem_rdata;

        // Output register drains on a completed transfer
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res       = '0;
                    n_res.event_res = EV_NONE;
                    n_fill_byte = 1'b0;
                    n_fill_addr = 1'b0;
                    n_state     = S_RD;
                    unique case (i_in_item.func)
                        FN_RX_BYTE: begin
                            if (i_in_item.parity_error || i_in_item.framing_error) begin
                                v_mode = M_ERR;
                            end
                            n_mode = v_mode;
                            if (v_mode == M_IDLE) begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = i_in_item.data;
                                n_rx_count = CW'(1);
                                n_mode     = M_RCV;
                            end else if (v_mode == M_RCV) begin
                                if (r_rx_count < LIM_CNT) begin
                                    mem_we     = 1'b1;
                                    mem_waddr  = r_rx_count[AW-1:0];
                                    mem_wdata  = i_in_item.data;
                                    n_rx_count = r_rx_count + CW'(1);
                                end else begin
                                    n_mode = M_ERR;
                                end
                            end
                        end
                        FN_EXPIRY: begin
                            mem_raddr = '0;
                            if (r_mode == M_INIT) begin
                                n_res.event_res = EV_INIT_DONE;
                            end else if (r_mode == M_RCV) begin
                                n_res.event_res = EV_FRAME_RX;
                                if (r_rx_count >= MIN_CNT) begin
                                    n_res.frame_ok      = 1'b1;
                                    n_res.rx_pdu_length = v_rlen[7:0];
                                    n_fill_addr         = 1'b1;
                                end
                            end
                            n_mode = M_IDLE;
                        end
                        FN_TX_READY: begin
                            if (!r_tx_busy) begin
                                n_rx_en = 1'b1;
                            end else if (r_tx_rem != '0) begin
                                n_res.event_res = EV_TX_BYTE;
                                n_res.tx_last   = (r_tx_rem == CW'(1));
                                mem_raddr       = r_tx_pos;
                                n_fill_byte     = 1'b1;
                                n_tx_pos        = r_tx_pos + AW'(1);
                                n_tx_rem        = r_tx_rem - CW'(1);
                            end else begin
                                n_res.event_res = EV_SENT;
                                n_drv_en        = 1'b0;
                                n_rx_en         = 1'b1;
                                n_tx_busy       = 1'b0;
                            end
                        end
                        FN_BUF_WR: begin
                            if ({1'b0, i_in_item.index} < LIM9) begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(i_in_item.index);
                                mem_wdata = i_in_item.data;
                            end
                        end
                        FN_BUF_RD: begin
                            n_res.event_res = EV_RD_DATA;
                            if ({1'b0, i_in_item.index} < LIM9) begin
                                mem_raddr   = AW'(i_in_item.index);
                                n_fill_byte = 1'b1;
                            end
                        end
                        FN_SEND: begin
                            if (r_mode != M_IDLE ||
                                ({1'b0, i_in_item.tx_pdu_length} + 9'd3) > LIM9) begin
                                n_res.event_res = EV_SEND_NAK;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_in_item.slave_id;
                                crc_clear = 1'b1;
                                n_sid     = i_in_item.slave_id;
                                n_plen    = i_in_item.tx_pdu_length;
                                n_state   = S_SID;
                            end
                        end
                        FN_START: begin
                            n_mode  = M_INIT;
                            n_rx_en = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Late buffer data joins the result
            S_RD: begin
                if (r_fill_byte) begin
                    n_res.byte_out = mem_rdata;
                end
                if (r_fill_addr) begin
                    n_res.address = mem_rdata;
                end
                n_state = S_PUT;
            end
            // Address byte goes through the CRC first
            S_SID: begin
                crc_en  = 1'b1;
                crc_in  = r_sid;
                n_ptr   = AW'(1);
                n_left  = r_plen;
                n_pend  = 1'b0;
                n_state = S_CRC;
            end
            // PDU walk: read issued here, byte folded in on the next cycle
            S_CRC: begin
                mem_raddr = r_ptr;
                crc_en    = r_pend;
                if (r_left != 8'd0) begin
                    n_ptr  = r_ptr + AW'(1);
                    n_left = r_left - 8'd1;
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_WLO;
                end
            end
            S_WLO: begin
                mem_we    = 1'b1;
                mem_waddr = AW'({1'b0, r_plen} + 9'd1);
                mem_wdata = crc_val[7:0];
                n_state   = S_WHI;
            end
            S_WHI: begin
                mem_we          = 1'b1;
                mem_waddr       = AW'({1'b0, r_plen} + 9'd2);
                mem_wdata       = crc_val[15:8];
                n_tx_pos        = '0;
                n_tx_rem        = CW'({1'b0, r_plen} + 9'd3);
                n_tx_busy       = 1'b1;
                n_rx_en         = 1'b0;
                n_drv_en        = 1'b1;
                n_res.event_res = EV_SEND_OK;
                n_state         = S_PUT;
            end
            // Hand the result to the output register when it is free
            S_PUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out             = r_res;
                    n_out.receiver_on = r_rx_en;
                    n_out.driver_on   = r_drv_en;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_INIT;
            r_tx_busy   <= 1'b0;
            r_rx_count  <= '0;
            r_tx_pos    <= '0;
            r_tx_rem    <= '0;
            r_rx_en     <= 1'b1;
            r_drv_en    <= 1'b0;
            r_fill_byte <= 1'b0;
            r_fill_addr <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_tx_busy   <= n_tx_busy;
            r_rx_count  <= n_rx_count;
            r_tx_pos    <= n_tx_pos;
            r_tx_rem    <= n_tx_rem;
            r_rx_en     <= n_rx_en;
            r_drv_en    <= n_drv_en;
            r_fill_byte <= n_fill_byte;
            r_fill_addr <= n_fill_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_res  <= n_res;
        r_out  <= n_out;
        r_sid  <= n_sid;
        r_plen <= n_plen;
        r_ptr  <= n_ptr;
        r_left <= n_left;
    end

endmodule

### sv/mrtu_chk.sv
`include "assert_macros.svh"

module mrtu_chk
    import mrtu_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_item
);

    // A stalled result keeps its payload
    `MRTU_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)),
        "result dropped or changed while stalled")

    // Bytes only go out while the line driver is on
    `MRTU_IMPLY(a_tx_drv, i_clk, i_rst_n,
        o_out_valid && o_out_item.event_res == EV_TX_BYTE,
        o_out_item.driver_on, "tx byte with driver off")

    // End of transmission hands the line back to the receiver
    `MRTU_IMPLY(a_sent_turn, i_clk, i_rst_n,
        o_out_valid && o_out_item.event_res == EV_SENT,
        o_out_item.receiver_on && !o_out_item.driver_on,
        "frame sent without line turnaround")

    // Flags belong to their own events only
    `MRTU_IMPLY(a_ok_ev, i_clk, i_rst_n, o_out_valid && o_out_item.frame_ok,
        o_out_item.event_res == EV_FRAME_RX, "frame_ok outside frame received")

    `MRTU_IMPLY(a_last_ev, i_clk, i_rst_n, o_out_valid && o_out_item.tx_last,
        o_out_item.event_res == EV_TX_BYTE, "tx_last outside tx byte")

endmodule

bind modbus_rtu_frame_engine mrtu_chk u_mrtu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
